>>> hdl/tower_seed_cluster_trigger_assert.svh
// Assertion macros shared by the seed cluster trigger RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TOWER_SEED_CLUSTER_TRIGGER_ASSERT_SVH
`define TOWER_SEED_CLUSTER_TRIGGER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define TSCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsct assertion failed");
// Next-cycle implication, checked out of reset.
`define TSCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsct assertion failed");
`else
`define TSCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TSCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/tsct_pkg.sv
// Shared types, constants and helpers of the seed cluster trigger.
// No dependencies; all other files but the assertion header use it by scoped names.
`timescale 1ns / 1ps

package tsct_pkg;

    localparam int ETA_BINS_DEF  = 40;
    localparam int PHI_BINS_DEF  = 120;
    localparam int CHANNELS_DEF  = 4800;
    localparam int MAX_SEEDS_DEF = 256;

    localparam int KIND_W  = 2;
    localparam int CHAN_W  = 13;
    localparam int TIDX_W  = 13;
    localparam int ET_W    = 16;
    localparam int SUM_W   = 18;
    localparam int CODE_W  = 8;
    localparam int ETA_W   = 6;
    localparam int PHI_W   = 7;

    localparam logic [KIND_W-1:0] KIND_MAP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOE = 2'd2;

    // Register index, taken from paddr bit 2.
    localparam logic REG_SEED_THR = 1'b0;
    localparam logic REG_CLU_THR  = 1'b1;

    localparam logic [ET_W-1:0]  SEED_THR_RST = 16'd320;
    localparam logic [SUM_W-1:0] CLU_THR_RST  = 18'd896;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = 3;

    // floor(x/15) for x < 3840 via x*4370 >> 16; saturated at 255 above.
    localparam int CODE_SAT   = 3840;
    localparam int CODE_MUL   = 4370;
    localparam int CODE_SHIFT = 16;

    typedef struct packed {
        logic              eoe;
        logic [TIDX_W-1:0] tower;
        logic [ET_W-1:0]   et;
    } t_op;

    typedef struct packed {
        logic [ET_W-1:0]  seed_thr;
        logic [SUM_W-1:0] clu_thr;
    } t_cfg;

    function automatic logic [CODE_W-1:0] et_code(input logic [SUM_W-1:0] x);
        logic [24:0] prod;
        prod = 25'(x[11:0]) * 25'(CODE_MUL);
        if (x >= SUM_W'(CODE_SAT)) begin
            return {CODE_W{1'b1}};
        end
        return prod[CODE_SHIFT +: CODE_W];
    endfunction

endpackage

>>> hdl/tsct_if.sv
// Valid/ready channel interfaces for input items and result words.
// Depends on tsct_pkg for the field widths.
`timescale 1ns / 1ps

interface tsct_item_if;
    logic                          valid;
    logic                          ready;
    logic [tsct_pkg::KIND_W-1:0]   kind;
    logic [tsct_pkg::CHAN_W-1:0]   channel;
    logic [tsct_pkg::TIDX_W-1:0]   tower_index;
    logic [tsct_pkg::ET_W-1:0]     hit_et;

    modport source (output valid, kind, channel, tower_index, hit_et, input ready);
    modport sink (input valid, kind, channel, tower_index, hit_et, output ready);
endinterface

interface tsct_result_if;
    logic                          valid;
    logic                          ready;
    logic                          accept;
    logic [tsct_pkg::ET_W-1:0]     seed_et;
    logic [tsct_pkg::SUM_W-1:0]    cluster_et;
    logic [tsct_pkg::CODE_W-1:0]   seed_code;
    logic [tsct_pkg::CODE_W-1:0]   cluster_code;
    logic [tsct_pkg::ETA_W-1:0]    seed_eta_bin;
    logic [tsct_pkg::PHI_W-1:0]    seed_phi_bin;

    modport source (output valid, accept, seed_et, cluster_et, seed_code, cluster_code,
                    seed_eta_bin, seed_phi_bin, input ready);
    modport sink (input valid, accept, seed_et, cluster_et, seed_code, cluster_code,
                  seed_eta_bin, seed_phi_bin, output ready);
endinterface

>>> hdl/tsct_fifo.sv
// Short operation queue between the front and back parts.
// Depends on tsct_pkg for the queue word type and depth.
`timescale 1ns / 1ps

module tsct_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  tsct_pkg::t_op               i_op,
    input  logic                        i_pop,
    output tsct_pkg::t_op               o_op,
    output logic                        o_empty,
    output logic [tsct_pkg::QLVL_W-1:0] o_level
);
    tsct_pkg::t_op                r_mem [tsct_pkg::QDEPTH];
    logic [tsct_pkg::QPTR_W-1:0]  r_wp, r_rp;
    logic [tsct_pkg::QLVL_W-1:0]  r_lvl;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_lvl <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_lvl <= r_lvl + 1'b1;
            end else if (!i_push && i_pop) begin
                r_lvl <= r_lvl - 1'b1;
            end
        end
    end

    assign o_op    = r_mem[r_rp];
    assign o_empty = (r_lvl == '0);
    assign o_level = r_lvl;
endmodule

>>> hdl/tsct_front.sv
// Front part: accepts input words, keeps the channel map, queues tower ops.
// Depends on tsct_pkg and tsct_item_if.
`timescale 1ns / 1ps

module tsct_front #(
    parameter int ETA_BINS = tsct_pkg::ETA_BINS_DEF,
    parameter int PHI_BINS = tsct_pkg::PHI_BINS_DEF,
    parameter int CHANNELS = tsct_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tsct_item_if.sink                   i_item,
    input  logic [tsct_pkg::QLVL_W-1:0] i_level,
    output logic                        o_push,
    output tsct_pkg::t_op               o_op
);
    localparam int NT = ETA_BINS * PHI_BINS;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [tsct_pkg::TIDX_W-1:0] r_map [CHANNELS];
    logic [tsct_pkg::TIDX_W-1:0] r_mq;
    logic                        r_pv, r_peoe;
    logic [tsct_pkg::ET_W-1:0]   r_pet;
    logic                        w_acc, w_chan_ok, w_tidx_ok;
    logic [CW-1:0]               w_cidx;

    // Room for the word in flight plus the one accepted now.
    assign i_item.ready = ({1'b0, i_level} + {{tsct_pkg::QLVL_W{1'b0}}, r_pv})
                          < (tsct_pkg::QLVL_W + 1)'(tsct_pkg::QDEPTH);
    assign w_acc     = i_item.valid && i_item.ready;
    assign w_chan_ok = int'(i_item.channel) < CHANNELS;
    assign w_tidx_ok = int'(i_item.tower_index) < NT;
    assign w_cidx    = CW'(i_item.channel);

    always_ff @(posedge i_clk) begin
        if (w_acc && w_chan_ok && i_item.kind == tsct_pkg::KIND_MAP && w_tidx_ok) begin
            r_map[w_cidx] <= i_item.tower_index;
        end
        if (w_acc && i_item.kind == tsct_pkg::KIND_HIT) begin
            r_mq <= r_map[w_cidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= w_acc && ((i_item.kind == tsct_pkg::KIND_HIT && w_chan_ok) ||
                              i_item.kind == tsct_pkg::KIND_EOE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_peoe <= (i_item.kind == tsct_pkg::KIND_EOE);
            r_pet  <= i_item.hit_et;
        end
    end

    // A never-written map entry may hold anything; keep it inside the store.
    assign o_push   = r_pv;
    assign o_op.eoe = r_peoe;
    assign o_op.et  = r_pet;
    assign o_op.tower = (int'(r_mq) < NT) ? r_mq : '0;
endmodule

>>> hdl/tsct_back.sv
// Back part: tower ET store, seed list, end-of-event cluster scan and clear.
// Depends on tsct_pkg, tsct_result_if and the assertion macro header.
`timescale 1ns / 1ps
`include "tower_seed_cluster_trigger_assert.svh"

module tsct_back #(
    parameter int ETA_BINS  = tsct_pkg::ETA_BINS_DEF,
    parameter int PHI_BINS  = tsct_pkg::PHI_BINS_DEF,
    parameter int MAX_SEEDS = tsct_pkg::MAX_SEEDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsct_pkg::t_op   i_op,
    input  logic            i_empty,
    output logic            o_pop,
    input  tsct_pkg::t_cfg  i_cfg,
    tsct_result_if.source   o_res
);
    localparam int NT  = ETA_BINS * PHI_BINS;
    localparam int TW  = $clog2(NT);
    localparam int MUL = (1 << TW) / ETA_BINS;
    localparam int IW  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int NW  = $clog2(MAX_SEEDS + 1);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_RUN    = 10'b0000000010,
        S_SL_RD  = 10'b0000000100,
        S_DIV1   = 10'b0000001000,
        S_DIV2   = 10'b0000010000,
        S_G_RD   = 10'b0000100000,
        S_G_ACC  = 10'b0001000000,
        S_SD_RD  = 10'b0010000000,
        S_SD_ACC = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [tsct_pkg::ET_W-1:0]  r_et_mem [NT];
    logic [TW-1:0]              r_sl_mem [MAX_SEEDS];
    logic [tsct_pkg::ET_W-1:0]  r_tq;
    logic [TW-1:0]              r_slq;

    logic [TW-1:0]              r_clr, r_t, r_eta, r_phi;
    logic [2*TW-1:0]            r_prod;
    logic [NW-1:0]              r_cnt, r_idx;
    logic [1:0]                 r_grp, r_k;
    logic [tsct_pkg::SUM_W-1:0] r_sum;
    logic [tsct_pkg::ET_W-1:0]  r_seed_et;
    logic                       r_acc, r_ov;

    logic [tsct_pkg::SUM_W-1:0] r_o_cet;
    logic [tsct_pkg::ET_W-1:0]  r_o_set;
    logic [tsct_pkg::CODE_W-1:0] r_o_scode, r_o_ccode;
    logic [tsct_pkg::ETA_W-1:0] r_o_eta;
    logic [tsct_pkg::PHI_W-1:0] r_o_phi;
    logic                       r_o_acc;

    logic                       w_hit, w_we, w_emit, w_seed;
    logic [TW-1:0]              w_waddr, w_raddr, w_htower;
    logic [tsct_pkg::ET_W-1:0]  w_wdata;
    logic [TW-1:0]              w_q, w_r, w_base, w_b1;
    logic [2*TW-1:0]            w_qe;
    logic [TW:0]                w_a;
    logic [TW-1:0]              w_gaddr;
    logic [tsct_pkg::SUM_W-1:0] w_sum;
    logic                       w_last_grp, w_more;

    assign o_pop    = (r_state == S_RUN) && !i_empty;
    assign w_hit    = o_pop && !i_op.eoe;
    assign w_htower = TW'(i_op.tower);
    assign w_seed   = w_hit && (i_op.et >= i_cfg.seed_thr) && (int'(r_cnt) < MAX_SEEDS);
    assign w_we     = w_hit || (r_state == S_CLEAR);
    assign w_waddr  = (r_state == S_CLEAR) ? r_clr : w_htower;
    assign w_wdata  = (r_state == S_CLEAR) ? '0 : i_op.et;
    assign w_raddr  = (r_state == S_G_RD) ? w_gaddr : r_t;
    assign w_emit   = (r_state == S_EMIT) && (!r_ov || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_et_mem[w_waddr] <= w_wdata;
        end
        r_tq <= r_et_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_seed) begin
            r_sl_mem[r_cnt[IW-1:0]] <= w_htower;
        end
        r_slq <= r_sl_mem[r_idx[IW-1:0]];
    end

    // Tower number to (phi, eta): reciprocal multiply, one correction step.
    assign w_qe = (2*TW)'(r_prod[2*TW-1:TW]) * (2*TW)'(ETA_BINS);
    always_comb begin
        w_q = r_prod[2*TW-1:TW];
        w_r = r_t - w_qe[TW-1:0];
        if (w_r >= TW'(ETA_BINS)) begin
            w_q = w_q + 1'b1;
            w_r = w_r - TW'(ETA_BINS);
        end
    end

    // Group bases: seed, row below (wrapping), both of those one eta lower.
    assign w_b1 = (r_phi == '0) ? r_t + TW'(NT - ETA_BINS) : r_t - TW'(ETA_BINS);
    always_comb begin
        case (r_grp)
            2'd0:    w_base = r_t;
            2'd1:    w_base = w_b1;
            2'd2:    w_base = w_b1 - 1'b1;
            default: w_base = r_t - 1'b1;
        endcase
        w_a = {1'b0, w_base} + (r_k[0] ? (TW+1)'(1) : '0)
              + (r_k[1] ? (TW+1)'(ETA_BINS) : '0);
        if (w_a >= (TW+1)'(NT)) begin
            w_a = w_a - (TW+1)'(NT);
        end
        w_gaddr = w_a[TW-1:0];
    end

    assign w_sum      = r_sum + tsct_pkg::SUM_W'(r_tq);
    assign w_last_grp = (r_grp == 2'd3) || (r_grp == 2'd1 && r_eta == '0);
    assign w_more     = (r_idx + 1'b1) < r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_grp   <= '0;
            r_k     <= '0;
            r_acc   <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == TW'(NT - 1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_seed) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (o_pop && i_op.eoe) begin
                        r_idx <= '0;
                        r_acc <= 1'b0;
                        r_state <= (r_cnt == '0) ? S_EMIT : S_SL_RD;
                    end
                end
                S_SL_RD: r_state <= S_DIV1;
                S_DIV1:  r_state <= S_DIV2;
                S_DIV2: begin
                    r_grp   <= '0;
                    r_k     <= '0;
                    r_state <= S_G_RD;
                end
                S_G_RD: r_state <= S_G_ACC;
                S_G_ACC: begin
                    r_k <= r_k + 1'b1;
                    if (r_k != 2'd3) begin
                        r_state <= S_G_RD;
                    end else if (w_sum > i_cfg.clu_thr) begin
                        r_state <= S_SD_RD;
                    end else if (!w_last_grp) begin
                        r_grp   <= r_grp + 1'b1;
                        r_state <= S_G_RD;
                    end else if (w_more) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SL_RD;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_SD_RD: r_state <= S_SD_ACC;
                S_SD_ACC: begin
                    r_acc   <= 1'b1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_clr   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // Scan datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV1) begin
            r_t    <= r_slq;
            r_prod <= (2*TW)'(r_slq) * (2*TW)'(MUL);
        end
        if (r_state == S_DIV2) begin
            r_phi <= w_q;
            r_eta <= w_r;
            r_sum <= '0;
        end
        if (r_state == S_G_ACC) begin
            r_sum <= (r_k == 2'd3 && !(w_sum > i_cfg.clu_thr)) ? '0 : w_sum;
        end
        if (r_state == S_SD_ACC) begin
            r_seed_et <= r_tq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    // A rejected event reports all fields as zero.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_acc   <= r_acc;
            r_o_set   <= r_acc ? r_seed_et : '0;
            r_o_cet   <= r_acc ? r_sum : '0;
            r_o_scode <= r_acc ? tsct_pkg::et_code(tsct_pkg::SUM_W'(r_seed_et)) : '0;
            r_o_ccode <= r_acc ? tsct_pkg::et_code(r_sum) : '0;
            r_o_eta   <= r_acc ? tsct_pkg::ETA_W'(r_eta) : '0;
            r_o_phi   <= r_acc ? tsct_pkg::PHI_W'(r_phi) : '0;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.accept       = r_o_acc;
    assign o_res.seed_et      = r_o_set;
    assign o_res.cluster_et   = r_o_cet;
    assign o_res.seed_code    = r_o_scode;
    assign o_res.cluster_code = r_o_ccode;
    assign o_res.seed_eta_bin = r_o_eta;
    assign o_res.seed_phi_bin = r_o_phi;

    `TSCT_ASSERT_IMPL(a_clr_range, i_clk, i_rst_n, r_state == S_CLEAR, int'(r_clr) < NT)
    `TSCT_ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, int'(r_cnt) <= MAX_SEEDS)
    `TSCT_ASSERT_IMPL(a_grp_eta, i_clk, i_rst_n, r_state == S_G_ACC, r_grp < 2'd2 || r_eta != '0)
    `TSCT_ASSERT_NEXT(a_emit_out, i_clk, i_rst_n, w_emit, r_ov && r_state == S_CLEAR)
endmodule

>>> hdl/tower_seed_cluster_trigger.sv
// Hits: one word per cycle while the queue has room; a hit goes via a front register
// and the queue to the tower store. End of event: per seed a list read, a divide, and
// sums over up to G four-tower groups (2 or 4), a seed ET read if it accepts, an emit,
// then a clear sweep (one port); words queue meanwhile until the four-entry queue fills.
// Synchronous active-low reset: registers restored, then the same clear sweep runs.
// Depends on tsct_pkg, tsct_if, tsct_fifo, tsct_front and tsct_back.
`timescale 1ns / 1ps

module tower_seed_cluster_trigger #(
    parameter int ETA_BINS  = tsct_pkg::ETA_BINS_DEF,
    parameter int PHI_BINS  = tsct_pkg::PHI_BINS_DEF,
    parameter int CHANNELS  = tsct_pkg::CHANNELS_DEF,
    parameter int MAX_SEEDS = tsct_pkg::MAX_SEEDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsct_item_if.sink    i_item,
    tsct_result_if.source o_result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    tsct_pkg::t_cfg              r_cfg;
    tsct_pkg::t_op               w_push_op, w_pop_op;
    logic                        w_push, w_pop, w_empty;
    logic [tsct_pkg::QLVL_W-1:0] w_level;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed_thr <= tsct_pkg::SEED_THR_RST;
            r_cfg.clu_thr  <= tsct_pkg::CLU_THR_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                tsct_pkg::REG_SEED_THR: r_cfg.seed_thr <= pwdata[tsct_pkg::ET_W-1:0];
                tsct_pkg::REG_CLU_THR:  r_cfg.clu_thr  <= pwdata[tsct_pkg::SUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tsct_pkg::REG_SEED_THR: prdata = 32'(r_cfg.seed_thr);
            tsct_pkg::REG_CLU_THR:  prdata = 32'(r_cfg.clu_thr);
            default:                prdata = '0;
        endcase
    end

    tsct_front #(
        .ETA_BINS (ETA_BINS),
        .PHI_BINS (PHI_BINS),
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_level (w_level),
        .o_push  (w_push),
        .o_op    (w_push_op)
    );

    tsct_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_pop_op),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    tsct_back #(
        .ETA_BINS  (ETA_BINS),
        .PHI_BINS  (PHI_BINS),
        .MAX_SEEDS (MAX_SEEDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_pop_op),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_cfg   (r_cfg),
        .o_res   (o_result)
    );
endmodule

>>> tb/tsct_checker.sv
// Scoreboard for the seed cluster trigger: watches the item, result and APB ports,
// predicts each end-of-event word and compares it field by field.
// Depends on tsct_pkg and the channel interfaces in tsct_if.
`timescale 1ns / 1ps

module tsct_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsct_item_if          item,
    tsct_result_if        result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            o_errors,
    output int            o_pending
);
    localparam int ETA   = tsct_pkg::ETA_BINS_DEF;
    localparam int PHI   = tsct_pkg::PHI_BINS_DEF;
    localparam int NTOW  = ETA * PHI;
    localparam int NCHAN = tsct_pkg::CHANNELS_DEF;
    localparam int NSEED = tsct_pkg::MAX_SEEDS_DEF;

    typedef struct packed {
        logic                        accept;
        logic [tsct_pkg::ET_W-1:0]   seed_et;
        logic [tsct_pkg::SUM_W-1:0]  cluster_et;
        logic [tsct_pkg::CODE_W-1:0] seed_code;
        logic [tsct_pkg::CODE_W-1:0] cluster_code;
        logic [tsct_pkg::ETA_W-1:0]  eta_bin;
        logic [tsct_pkg::PHI_W-1:0]  phi_bin;
    } t_trig_word;

    logic [tsct_pkg::ET_W-1:0]   tower_et [NTOW];
    logic [tsct_pkg::TIDX_W-1:0] chan_tower [NCHAN];
    int                          seed_towers [$];
    logic [tsct_pkg::ET_W-1:0]   seed_thr;
    logic [tsct_pkg::SUM_W-1:0]  clu_thr;
    t_trig_word                  pending_triggers [$];
    int                          errors;

    assign o_errors  = errors;
    assign o_pending = pending_triggers.size();

    function automatic logic [tsct_pkg::CODE_W-1:0] gev_code(input int unsigned et);
        return (et / 15 > 255) ? 8'hFF : tsct_pkg::CODE_W'(et / 15);
    endfunction

    function automatic string fmt_word(input t_trig_word w);
        return $sformatf("acc=%0d seed=%0d clu=%0d sc=%0d cc=%0d eta=%0d phi=%0d",
                         w.accept, w.seed_et, w.cluster_et, w.seed_code,
                         w.cluster_code, w.eta_bin, w.phi_bin);
    endfunction

    function automatic int unsigned quad_sum(input int phi, input int eta);
        int b;
        int c;
        b = (phi % PHI) * ETA + (eta % ETA);
        c = (b + ETA) % NTOW;
        return tower_et[b] + tower_et[(b + 1) % NTOW] + tower_et[c]
             + tower_et[(c + 1) % NTOW];
    endfunction

    // Scans the seeds in arrival order; the first group above threshold wins.
    function automatic t_trig_word scan_event();
        t_trig_word w;
        int unsigned sums [4];
        int t, eta, phi, phm, n;
        w = '0;
        foreach (seed_towers[i]) begin
            t   = seed_towers[i];
            eta = t % ETA;
            phi = t / ETA;
            phm = (phi + PHI - 1) % PHI;
            sums[0] = quad_sum(phi, eta);
            sums[1] = quad_sum(phm, eta);
            n = 2;
            if (eta > 0) begin
                sums[2] = quad_sum(phm, eta - 1);
                sums[3] = quad_sum(phi, eta - 1);
                n = 4;
            end
            for (int g = 0; g < n; g++) begin
                if (sums[g] > clu_thr) begin
                    w.accept       = 1'b1;
                    w.seed_et      = tower_et[t];
                    w.cluster_et   = tsct_pkg::SUM_W'(sums[g]);
                    w.seed_code    = gev_code(tower_et[t]);
                    w.cluster_code = gev_code(sums[g]);
                    w.eta_bin      = tsct_pkg::ETA_W'(eta);
                    w.phi_bin      = tsct_pkg::PHI_W'(phi);
                    return w;
                end
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_trig_word got;
        t_trig_word want;
        int t;
        if (!i_rst_n) begin
            seed_thr = tsct_pkg::SEED_THR_RST;
            clu_thr  = tsct_pkg::CLU_THR_RST;
            seed_towers.delete();
            pending_triggers.delete();
            errors = 0;
            foreach (tower_et[i]) tower_et[i] = '0;
            foreach (chan_tower[i]) chan_tower[i] = '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == tsct_pkg::REG_SEED_THR) seed_thr = pwdata[tsct_pkg::ET_W-1:0];
                else clu_thr = pwdata[tsct_pkg::SUM_W-1:0];
            end
            if (item.valid && item.ready) begin
                case (item.kind)
                    tsct_pkg::KIND_MAP: begin
                        if (item.channel < NCHAN && item.tower_index < NTOW)
                            chan_tower[item.channel] = item.tower_index;
                    end
                    tsct_pkg::KIND_HIT: begin
                        if (item.channel < NCHAN) begin
                            t = chan_tower[item.channel] % NTOW;
                            tower_et[t] = item.hit_et;
                            if (item.hit_et >= seed_thr && seed_towers.size() < NSEED)
                                seed_towers.push_back(t);
                        end
                    end
                    tsct_pkg::KIND_EOE: begin
                        pending_triggers.push_back(scan_event());
                        foreach (tower_et[i]) tower_et[i] = '0;
                        seed_towers.delete();
                    end
                    default: ;
                endcase
            end
            if (result.valid && result.ready) begin
                got = '{result.accept, result.seed_et, result.cluster_et, result.seed_code,
                        result.cluster_code, result.seed_eta_bin, result.seed_phi_bin};
                if (pending_triggers.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("Unexpected trigger word %s", fmt_word(got));
                end else begin
                    want = pending_triggers.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("Trigger mismatch: expected %s, got %s",
                                     fmt_word(want), fmt_word(got));
                    end
                end
            end
        end
    end
endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the seed cluster trigger: map loads, hit events,
// end-of-event scans, APB threshold changes and random output back-pressure.
// Depends on tsct_pkg, tsct_if, the trigger RTL and tsct_checker.
`timescale 1ns / 1ps

module tb_top;
    localparam int ETA  = tsct_pkg::ETA_BINS_DEF;
    localparam int PHI  = tsct_pkg::PHI_BINS_DEF;
    localparam int NTOW = ETA * PHI;
    localparam int NCHAN = tsct_pkg::CHANNELS_DEF;
    localparam int SWEEP_WAIT = 5200;
    localparam int CYCLE_LIMIT = 3000000;
    // Kind code that the block ignores.
    localparam logic [tsct_pkg::KIND_W-1:0] KIND_RSVD = 2'd3;
    localparam logic [2:0] ADDR_SEED_THR = {tsct_pkg::REG_SEED_THR, 2'b00};
    localparam logic [2:0] ADDR_CLU_THR  = {tsct_pkg::REG_CLU_THR, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    int          cycles;
    int          burst_left;
    int          stall_pct;
    bit          hold_req;
    bit          chan_mapped [NCHAN];

    tsct_item_if   item_if();
    tsct_result_if result_if();

    tower_seed_cluster_trigger dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_if), .o_result(result_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tsct_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .item(item_if), .result(result_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output back-pressure: random stall pattern, plus one long hold on request.
    initial begin
        int hold_cnt;
        result_if.ready <= 1'b0;
        hold_cnt = 0;
        stall_pct = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 40000;
                hold_req = 0;
            end
            if (cycles % 256 == 0) stall_pct = ($urandom_range(0, 2)) * 35;
            if (hold_cnt > 0) begin
                hold_cnt--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offers one word and waits for it to be taken; valid drops only in gaps.
    task automatic send(input logic [tsct_pkg::KIND_W-1:0] kind, input int ch,
                        input int tidx, input int et);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_if.valid       <= 1'b1;
        item_if.kind        <= kind;
        item_if.channel     <= tsct_pkg::CHAN_W'(ch);
        item_if.tower_index <= tsct_pkg::TIDX_W'(tidx);
        item_if.hit_et      <= tsct_pkg::ET_W'(et);
        do @(posedge i_clk); while (!item_if.ready);
        burst_left--;
        if (kind == tsct_pkg::KIND_MAP && ch < NCHAN && tidx < NTOW) chan_mapped[ch] = 1;
    endtask

    task automatic idle_wait();
        item_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SWEEP_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input int unsigned data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Maps channels 0..63 into an 8x8 patch of towers so clusters can form.
    task automatic load_patch(input int phi0, input int eta0);
        for (int c = 0; c < 64; c++)
            send(tsct_pkg::KIND_MAP, c, ((phi0 + c / 8) % PHI) * ETA
                                        + (eta0 + c % 8) % ETA, $urandom_range(0, 65535));
    endtask

    function automatic int pick_et(input int thr);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 600);
            2: return (thr > 20) ? thr + $urandom_range(0, 40) - 20 : $urandom_range(0, 40);
            default: return $urandom_range(200, 4000);
        endcase
    endfunction

    task automatic random_phase(input int n_items, input int thr);
        int ch;
        int sent;
        sent = 0;
        load_patch($urandom_range(0, 1) ? 0 : $urandom_range(0, PHI - 1),
                   $urandom_range(0, 1) ? 36 : $urandom_range(0, ETA - 1));
        while (sent < n_items) begin
            case ($urandom_range(0, 99)) inside
                [0:7]: send(tsct_pkg::KIND_EOE, $urandom_range(0, 8191),
                            $urandom_range(0, 8191), $urandom_range(0, 65535));
                [8:10]: send(tsct_pkg::KIND_MAP, $urandom_range(0, 8191),
                             $urandom_range(0, 8191), $urandom_range(0, 65535));
                [11:12]: send(KIND_RSVD, $urandom_range(0, 8191), $urandom_range(0, 8191),
                              $urandom_range(0, 65535));
                [13:14]: send(tsct_pkg::KIND_HIT, $urandom_range(NCHAN, 8191),
                              $urandom_range(0, 8191), $urandom_range(0, 65535));
                default: begin
                    do ch = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, NCHAN - 1);
                    while (!chan_mapped[ch]);
                    send(tsct_pkg::KIND_HIT, ch, $urandom_range(0, 8191), pick_et(thr));
                end
            endcase
            sent++;
        end
        send(tsct_pkg::KIND_EOE, 0, 0, 0);
        idle_wait();
    endtask

    initial begin
        cycles = 0;
        burst_left = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        item_if.valid = 1'b0; item_if.kind = '0; item_if.channel = '0;
        item_if.tower_index = '0; item_if.hit_et = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SWEEP_WAIT) @(posedge i_clk);

        // Directed: edge towers, ignored writes and hits, wrap, repeats, empty event.
        send(tsct_pkg::KIND_MAP, 4799, 4799, 0);
        send(tsct_pkg::KIND_MAP, 0, 0, 65535);
        send(tsct_pkg::KIND_MAP, 1, 39, 0);
        send(tsct_pkg::KIND_MAP, 2, 40, 0);
        send(tsct_pkg::KIND_MAP, 5, 4800, 0);
        send(tsct_pkg::KIND_MAP, 8191, 123, 0);
        send(tsct_pkg::KIND_HIT, 4799, 0, 65535);
        send(tsct_pkg::KIND_HIT, 0, 0, 0);
        send(tsct_pkg::KIND_HIT, 0, 0, 500);
        send(tsct_pkg::KIND_HIT, 1, 0, 320);
        send(tsct_pkg::KIND_HIT, 8191, 8191, 65535);
        send(KIND_RSVD, 8191, 8191, 65535);
        send(tsct_pkg::KIND_EOE, 0, 0, 0);
        send(tsct_pkg::KIND_EOE, 8191, 8191, 65535);
        send(tsct_pkg::KIND_HIT, 2, 0, 319);
        send(tsct_pkg::KIND_HIT, 0, 0, 1000);
        send(tsct_pkg::KIND_HIT, 2, 0, 65535);
        send(tsct_pkg::KIND_HIT, 4799, 0, 4000);
        send(tsct_pkg::KIND_EOE, 0, 0, 0);
        idle_wait();

        random_phase(100, 320);
        apb_write(ADDR_SEED_THR, 0);
        apb_write(ADDR_CLU_THR, 0);
        idle_wait();
        random_phase(80, 0);
        // Seed list overflow: every hit is a seed at threshold zero.
        for (int i = 0; i < 300; i++)
            send(tsct_pkg::KIND_HIT, $urandom_range(0, 63), 0,
                 $urandom_range(0, 1) ? 0 : $urandom_range(0, 900));
        send(tsct_pkg::KIND_EOE, 0, 0, 0);
        idle_wait();
        apb_write(ADDR_SEED_THR, 65535);
        apb_write(ADDR_CLU_THR, 262140);
        idle_wait();
        random_phase(60, 65535);
        apb_write(ADDR_SEED_THR, $urandom_range(100, 3000));
        apb_write(ADDR_CLU_THR, $urandom_range(200, 6000));
        idle_wait();
        // Long receiver hold while end-of-event words pile up behind it.
        hold_req = 1;
        for (int i = 0; i < 10; i++) send(tsct_pkg::KIND_EOE, 0, 0, 0);
        idle_wait();
        random_phase(100, 1000);
        apb_write(ADDR_SEED_THR, 320);
        apb_write(ADDR_CLU_THR, 896);
        idle_wait();
        random_phase(100, 320);

        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
